// ----- src/ikm_pkg.sv -----
package ikm_pkg;

    localparam int DEF_MAX_KEYWORDS    = 16;
    localparam int DEF_MAX_KEYWORD_LEN = 8;

    localparam int CFG_W = 5;

    localparam logic STATUS_MATCH = 1'b0;
    localparam logic STATUS_NONE  = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE_CHAR    = 2'd0,
        OP_WRITE_LEN_KEY = 2'd1,
        OP_MATCH         = 2'd2,
        OP_RESTART       = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [3:0]  entry_index;
        logic [2:0]  char_position;
        logic [7:0]  byte_value;
        logic [3:0]  entry_length;
        logic [7:0]  entry_key;
    } t_cmd;

    typedef struct packed {
        logic        status;
        logic [7:0]  matched_key;
    } t_res;

    // scan token phase as it walks down the chain
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_LAST  = 2'd1,
        PH_DONE  = 2'd2
    } t_phase;

    typedef struct packed {
        logic   valid;
        t_phase phase;
    } t_tok_ctl;

endpackage

// ----- src/ikm_cell.sv -----
module ikm_cell
    import ikm_pkg::*;
#(
    parameter int MAX_KEYWORDS    = DEF_MAX_KEYWORDS,
    parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN,
    parameter int INDEX           = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_we,
    input  t_cmd                                 i_cmd,
    input  logic [7:0]                           i_byte,
    input  logic [$clog2(MAX_KEYWORD_LEN+1)-1:0] i_pos,
    input  logic [$clog2(MAX_KEYWORDS+1)-1:0]    i_first,
    input  logic [$clog2(MAX_KEYWORDS+1)-1:0]    i_last,
    input  t_tok_ctl                             i_ctl,
    input  logic [$clog2(MAX_KEYWORDS+1)-1:0]    i_nf,
    input  logic [$clog2(MAX_KEYWORDS+1)-1:0]    i_nl,
    input  logic [$clog2(MAX_KEYWORD_LEN+1)-1:0] i_len,
    input  logic [7:0]                           i_key,
    output t_tok_ctl                             o_ctl,
    output logic [$clog2(MAX_KEYWORDS+1)-1:0]    o_nf,
    output logic [$clog2(MAX_KEYWORDS+1)-1:0]    o_nl,
    output logic [$clog2(MAX_KEYWORD_LEN+1)-1:0] o_len,
    output logic [7:0]                           o_key
);

    localparam int IW = $clog2(MAX_KEYWORDS + 1);
    localparam int LW = $clog2(MAX_KEYWORD_LEN + 1);
    localparam int CW = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [7:0]    r_chars [MAX_KEYWORD_LEN];
    logic [LW-1:0] r_len;
    logic [7:0]    r_key;

    t_tok_ctl      r_ctl, n_ctl;
    logic [IW-1:0] r_nf, n_nf;
    logic [IW-1:0] r_nl, n_nl;
    logic [LW-1:0] r_tlen, n_tlen;
    logic [7:0]    r_tkey, n_tkey;

    logic [31:0]   cpos32;
    logic [31:0]   len32;
    logic [31:0]   len_sat;
    logic          sel;
    logic          wr_char;
    logic          wr_len;
    logic          in_rng;
    logic          too_short;
    logic [7:0]    cur_char;
    logic          below;
    logic          above;

    assign cpos32  = 32'(i_cmd.char_position);
    assign len32   = 32'(i_cmd.entry_length);
    assign len_sat = (len32 > MAX_KEYWORD_LEN) ? 32'(MAX_KEYWORD_LEN) : len32;
    assign sel     = i_we && (32'(i_cmd.entry_index) == 32'(INDEX));
    assign wr_char = sel && (i_cmd.opcode == OP_WRITE_CHAR) && (cpos32 < MAX_KEYWORD_LEN);
    assign wr_len  = sel && (i_cmd.opcode == OP_WRITE_LEN_KEY);

    always_ff @(posedge i_clk) begin
        if (wr_char) begin
            r_chars[cpos32[CW-1:0]] <= i_cmd.byte_value;
        end
        if (wr_len) begin
            r_len <= len_sat[LW-1:0];
            r_key <= i_cmd.entry_key;
        end
    end

    // a too-short entry counts as both below and above the byte
    assign in_rng    = (MY_IDX >= i_first) && (MY_IDX < i_last);
    assign too_short = (i_pos >= r_len);
    assign cur_char  = r_chars[i_pos[CW-1:0]];
    assign below     = too_short || (cur_char < i_byte);
    assign above     = too_short || (cur_char > i_byte);

    always_comb begin
        n_ctl  = i_ctl;
        n_nf   = i_nf;
        n_nl   = i_nl;
        n_tlen = i_len;
        n_tkey = i_key;
        if (i_ctl.valid && in_rng) begin
            case (i_ctl.phase)
                PH_FIRST: begin
                    if (!below) begin
                        n_nf   = MY_IDX;
                        n_tlen = r_len;
                        n_tkey = r_key;
                        if (above) begin
                            n_nl        = MY_IDX;
                            n_ctl.phase = PH_DONE;
                        end else begin
                            n_ctl.phase = PH_LAST;
                        end
                    end
                end
                PH_LAST: begin
                    if (above) begin
                        n_nl        = MY_IDX;
                        n_ctl.phase = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '{valid: 1'b0, phase: PH_FIRST};
        end else begin
            r_ctl <= n_ctl;
        end
        r_nf   <= n_nf;
        r_nl   <= n_nl;
        r_tlen <= n_tlen;
        r_tkey <= n_tkey;
    end

    assign o_ctl = r_ctl;
    assign o_nf  = r_nf;
    assign o_nl  = r_nl;
    assign o_len = r_tlen;
    assign o_key = r_tkey;

endmodule

// ----- src/incremental_keyword_matcher_top.sv -----
// channel   ports                          transfer
// command   start, busy, i_cmd             rising edge with start high and busy low
// result    o_res_valid, o_res             one cycle strobe, taken at the end of it
// config    i_cfg_we, i_cfg_wdata          rising edge with i_cfg_we high
//
// a match byte walks a token down the row of MAX_KEYWORDS cells, one cell per
// cycle; when it leaves the last cell busy falls, and the result strobe, if the
// byte ends the search, rises with it
// loads and restart complete in the transfer cycle, busy stays low
// reset is synchronous, active low; it clears progress and the count, the
// keyword table itself is not cleared
// the receiver cannot stall; each result is shown for exactly one cycle
module incremental_keyword_matcher_top
    import ikm_pkg::*;
#(
    parameter int MAX_KEYWORDS    = DEF_MAX_KEYWORDS,
    parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    output logic             o_res_valid,
    output t_res             o_res,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int IW = $clog2(MAX_KEYWORDS + 1);
    localparam int LW = $clog2(MAX_KEYWORD_LEN + 1);

    logic          r_busy, n_busy;
    t_tok_ctl      r_launch, n_launch;
    logic [7:0]    r_byte, n_byte;
    logic [IW-1:0] r_count, n_count;
    logic [IW-1:0] r_first, n_first;
    logic [IW-1:0] r_last, n_last;
    logic [LW-1:0] r_pos, n_pos;
    logic          r_res_valid, n_res_valid;
    t_res          r_res, n_res;

    t_tok_ctl      c_ctl [MAX_KEYWORDS+1];
    logic [IW-1:0] c_nf  [MAX_KEYWORDS+1];
    logic [IW-1:0] c_nl  [MAX_KEYWORDS+1];
    logic [LW-1:0] c_len [MAX_KEYWORDS+1];
    logic [7:0]    c_key [MAX_KEYWORDS+1];

    logic          accept;
    logic [31:0]   cfg32;
    logic [IW-1:0] cfg_sat;
    logic [IW-1:0] fin_first;
    logic [IW-1:0] fin_last;
    logic          fin_empty;
    logic          fin_hit;

    assign accept  = start && !r_busy;
    assign cfg32   = 32'(i_cfg_wdata);
    assign cfg_sat = (cfg32 > MAX_KEYWORDS) ? IW'(MAX_KEYWORDS) : IW'(cfg32);

    assign c_ctl[0] = r_launch;
    assign c_nf[0]  = '0;
    assign c_nl[0]  = '0;
    assign c_len[0] = '0;
    assign c_key[0] = '0;

    for (genvar g = 0; g < MAX_KEYWORDS; g++) begin : g_cell
        ikm_cell #(
            .MAX_KEYWORDS    (MAX_KEYWORDS),
            .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
            .INDEX           (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_we    (accept),
            .i_cmd   (i_cmd),
            .i_byte  (r_byte),
            .i_pos   (r_pos),
            .i_first (r_first),
            .i_last  (r_last),
            .i_ctl   (c_ctl[g]),
            .i_nf    (c_nf[g]),
            .i_nl    (c_nl[g]),
            .i_len   (c_len[g]),
            .i_key   (c_key[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_nf    (c_nf[g+1]),
            .o_nl    (c_nl[g+1]),
            .o_len   (c_len[g+1]),
            .o_key   (c_key[g+1])
        );
    end

    // bounds still open at the end of the row close at the old last
    always_comb begin
        case (c_ctl[MAX_KEYWORDS].phase)
            PH_FIRST: begin
                fin_first = r_last;
                fin_last  = r_last;
            end
            PH_LAST: begin
                fin_first = c_nf[MAX_KEYWORDS];
                fin_last  = r_last;
            end
            default: begin
                fin_first = c_nf[MAX_KEYWORDS];
                fin_last  = c_nl[MAX_KEYWORDS];
            end
        endcase
    end

    assign fin_empty = (fin_last == fin_first);
    assign fin_hit   = ({1'b0, fin_last} == ({1'b0, fin_first} + 1'b1))
                    && ({1'b0, c_len[MAX_KEYWORDS]} == ({1'b0, r_pos} + 1'b1));

    always_comb begin
        n_busy      = r_busy;
        n_launch    = '{valid: 1'b0, phase: PH_FIRST};
        n_byte      = r_byte;
        n_count     = r_count;
        n_first     = r_first;
        n_last      = r_last;
        n_pos       = r_pos;
        n_res_valid = 1'b0;
        n_res       = r_res;
        if (i_cfg_we) begin
            n_count = cfg_sat;
            n_first = '0;
            n_last  = cfg_sat;
            n_pos   = '0;
        end else if (accept) begin
            case (i_cmd.opcode)
                OP_MATCH: begin
                    n_busy   = 1'b1;
                    n_launch = '{valid: 1'b1, phase: PH_FIRST};
                    n_byte   = i_cmd.byte_value;
                end
                OP_RESTART: begin
                    n_first = '0;
                    n_last  = r_count;
                    n_pos   = '0;
                end
                default: begin
                end
            endcase
        end else if (c_ctl[MAX_KEYWORDS].valid) begin
            n_busy = 1'b0;
            if (fin_empty || fin_hit) begin
                n_res_valid       = 1'b1;
                n_res.status      = fin_empty ? STATUS_NONE : STATUS_MATCH;
                n_res.matched_key = fin_empty ? 8'd0 : c_key[MAX_KEYWORDS];
                n_first           = '0;
                n_last            = r_count;
                n_pos             = '0;
            end else begin
                n_first = fin_first;
                n_last  = fin_last;
                n_pos   = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_launch    <= '{valid: 1'b0, phase: PH_FIRST};
            r_count     <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_pos       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_launch    <= n_launch;
            r_count     <= n_count;
            r_first     <= n_first;
            r_last      <= n_last;
            r_pos       <= n_pos;
            r_res_valid <= n_res_valid;
        end
        r_byte <= n_byte;
        r_res  <= n_res;
    end

    assign busy        = r_busy;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- src/ikm_checker.sv -----
module ikm_checker
    import ikm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_cmd i_cmd,
    input logic o_res_valid,
    input t_res o_res
);

    // scans pass r_launch and the cells, so strobes never touch
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobes in consecutive cycles");

    a_none_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status == STATUS_NONE)) |-> (o_res.matched_key == 8'd0))
        else $error("no-match result with nonzero key");

    a_match_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.opcode == OP_MATCH)) |=> busy)
        else $error("match byte transfer did not raise busy");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.opcode != OP_MATCH)) |=> (!busy && !o_res_valid))
        else $error("load or restart stalled or produced a result");

    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result without a scan in progress");

endmodule

bind incremental_keyword_matcher_top ikm_checker u_ikm_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

import ikm_pkg::*;

class keyword_match_checker;
    logic [7:0]  kw_chars [DEF_MAX_KEYWORDS][DEF_MAX_KEYWORD_LEN];
    int unsigned kw_lens  [DEF_MAX_KEYWORDS];
    logic [7:0]  kw_keys  [DEF_MAX_KEYWORDS];
    int unsigned kw_count;
    int unsigned range_lo;
    int unsigned range_hi;
    int unsigned matched_len;
    t_res        expected_results [$];
    int          errors;

    function new();
        for (int e = 0; e < DEF_MAX_KEYWORDS; e++) begin
            kw_lens[e] = 0;
            kw_keys[e] = '0;
            for (int p = 0; p < DEF_MAX_KEYWORD_LEN; p++) kw_chars[e][p] = '0;
        end
        kw_count = 0;
        errors   = 0;
        restart();
    endfunction

    function void restart();
        range_lo    = 0;
        range_hi    = kw_count;
        matched_len = 0;
    endfunction

    function void set_count(input logic [CFG_W-1:0] v);
        kw_count = (v > DEF_MAX_KEYWORDS) ? DEF_MAX_KEYWORDS : v;
        restart();
    endfunction

    function void note_error(input string msg);
        errors++;
        if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    // entry sorts before the byte at the current position (short entries count as below)
    function bit is_below(input int unsigned e, input logic [7:0] b);
        if (matched_len >= kw_lens[e]) return 1'b1;
        return kw_chars[e][matched_len] < b;
    endfunction

    function bit is_above(input int unsigned e, input logic [7:0] b);
        if (matched_len >= kw_lens[e]) return 1'b1;
        return kw_chars[e][matched_len] > b;
    endfunction

    function void note_command(input t_cmd c);
        int unsigned lo;
        int unsigned hi;
        t_res        r;
        case (c.opcode)
            OP_WRITE_CHAR: begin
                kw_chars[c.entry_index][c.char_position] = c.byte_value;
            end
            OP_WRITE_LEN_KEY: begin
                kw_lens[c.entry_index] = (c.entry_length > DEF_MAX_KEYWORD_LEN) ?
                                         DEF_MAX_KEYWORD_LEN : c.entry_length;
                kw_keys[c.entry_index] = c.entry_key;
            end
            OP_RESTART: begin
                restart();
            end
            OP_MATCH: begin
                lo = range_lo;
                while (lo < range_hi && is_below(lo, c.byte_value)) lo++;
                hi = lo;
                while (hi < range_hi && !is_above(hi, c.byte_value)) hi++;
                range_lo = lo;
                range_hi = hi;
                matched_len++;
                if (hi == lo) begin
                    r.status      = STATUS_NONE;
                    r.matched_key = '0;
                    expected_results.push_back(r);
                    restart();
                end else if (hi - lo == 1 && kw_lens[lo] == matched_len) begin
                    r.status      = STATUS_MATCH;
                    r.matched_key = kw_keys[lo];
                    expected_results.push_back(r);
                    restart();
                end
            end
        endcase
    endfunction

    function void check_result(input t_res got);
        t_res want;
        if (expected_results.size() == 0) begin
            note_error($sformatf("unexpected result status=%0d key=0x%02h",
                                 got.status, got.matched_key));
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status || got.matched_key !== want.matched_key)
            note_error($sformatf("expected status=%0d key=0x%02h, got status=%0d key=0x%02h",
                                 want.status, want.matched_key, got.status, got.matched_key));
    endfunction
endclass

module tb_top;
    localparam int TOTAL_ITEMS   = 1150;
    localparam int QUIET_AFTER   = 1000;
    localparam int SETTLE_CYCLES = DEF_MAX_KEYWORDS + 4;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_cmd             i_cmd       = '0;
    logic             o_res_valid;
    t_res             o_res;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    keyword_match_checker sb;
    int                   n_sent  = 0;
    int                   gap_pct = 0;

    // keyword table being loaded: chars packed first-char-high, zero padded
    logic [63:0] tbl_word [DEF_MAX_KEYWORDS];
    int          tbl_len  [DEF_MAX_KEYWORDS];

    incremental_keyword_matcher_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) sb.check_result(o_res);
    end

    function automatic t_cmd rand_cmd(input t_opcode op);
        t_cmd c;
        c.opcode        = op;
        c.entry_index   = 4'($urandom_range(0, 15));
        c.char_position = 3'($urandom_range(0, 7));
        c.byte_value    = 8'($urandom_range(0, 255));
        c.entry_length  = 4'($urandom_range(0, 15));
        c.entry_key     = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic send_cmd(input t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(c);
        n_sent++;
        if (n_sent < QUIET_AFTER && $urandom_range(1, 100) <= gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic send_match(input logic [7:0] b);
        t_cmd c;
        c = rand_cmd(OP_MATCH);
        c.byte_value = b;
        send_cmd(c);
    endtask

    task automatic send_char(input int e, input int p, input logic [7:0] b);
        t_cmd c;
        c = rand_cmd(OP_WRITE_CHAR);
        c.entry_index   = 4'(e);
        c.char_position = 3'(p);
        c.byte_value    = b;
        send_cmd(c);
    endtask

    task automatic send_len_key(input int e, input int len, input logic [7:0] key);
        t_cmd c;
        c = rand_cmd(OP_WRITE_LEN_KEY);
        c.entry_index  = 4'(e);
        c.entry_length = 4'(len);
        c.entry_key    = key;
        send_cmd(c);
    endtask

    // a match byte may end without a result, so let the scan drain too
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input int v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(v);
        @(posedge i_clk);
        sb.set_count(CFG_W'(v));
        i_cfg_we    <= 1'b0;
    endtask

    function automatic void make_table(input int n, input bit narrow);
        logic [63:0] w;
        int          len;
        int          j;
        for (int i = 0; i < n; i++) begin
            len = $urandom_range(1, DEF_MAX_KEYWORD_LEN);
            w   = '0;
            for (int p = 0; p < len; p++)
                w[63 - 8*p -: 8] = narrow ? 8'($urandom_range(8'h61, 8'h63))
                                          : 8'($urandom_range(1, 255));
            tbl_word[i] = w;
            tbl_len[i]  = len;
        end
        // zero padding makes numeric order the same as prefix-first lexical order
        for (int i = 1; i < n; i++) begin
            j = i;
            while (j > 0 && tbl_word[j] < tbl_word[j-1]) begin
                w             = tbl_word[j];
                tbl_word[j]   = tbl_word[j-1];
                tbl_word[j-1] = w;
                len           = tbl_len[j];
                tbl_len[j]    = tbl_len[j-1];
                tbl_len[j-1]  = len;
                j--;
            end
        end
    endfunction

    task automatic load_table(input int n);
        int len;
        for (int e = 0; e < n; e++) begin
            for (int p = 0; p < DEF_MAX_KEYWORD_LEN; p++)
                send_char(e, p, tbl_word[e][63 - 8*p -: 8]);
            len = tbl_len[e];
            // oversized length field saturates to the max
            if (len == DEF_MAX_KEYWORD_LEN && $urandom_range(0, 3) == 0)
                len = $urandom_range(DEF_MAX_KEYWORD_LEN, 15);
            send_len_key(e, len, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase();
        int n;
        int pick;
        int e;
        int cut;
        int cnt;
        n    = $urandom_range(1, DEF_MAX_KEYWORDS);
        pick = $urandom_range(0, 9);
        if (pick >= 8) n = DEF_MAX_KEYWORDS;
        gap_pct = 20 * $urandom_range(0, 2);
        make_table(n, $urandom_range(0, 2) != 0);
        load_table(n);
        cnt = (pick == 0) ? 0 : (pick == 9) ? $urandom_range(DEF_MAX_KEYWORDS + 1, 31) : n;
        write_count(cnt);
        for (int k = 0; k < 40; k++) begin
            if (n_sent >= TOTAL_ITEMS) break;
            pick = $urandom_range(0, 99);
            e    = $urandom_range(0, n - 1);
            if (pick < 60) begin
                for (int p = 0; p < tbl_len[e]; p++) send_match(tbl_word[e][63 - 8*p -: 8]);
            end else if (pick < 75) begin
                cut = $urandom_range(0, tbl_len[e] - 1);
                for (int p = 0; p < cut; p++) send_match(tbl_word[e][63 - 8*p -: 8]);
                send_match(8'($urandom_range(0, 255)));
            end else if (pick < 85) begin
                send_match(8'($urandom_range(0, 255)));
            end else if (pick < 92) begin
                send_cmd(rand_cmd(OP_RESTART));
            end else if (pick < 96) begin
                send_cmd(rand_cmd(OP_WRITE_CHAR));
            end else begin
                send_cmd(rand_cmd(OP_WRITE_LEN_KEY));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table
        write_count(0);
        send_match(8'h00);
        send_match(8'hFF);

        // every entry gets written before any count covers it
        make_table(DEF_MAX_KEYWORDS, 1'b0);
        tbl_word[0] = '0;                    tbl_len[0] = 0;
        tbl_word[1] = '0;                    tbl_len[1] = 1;
        tbl_word[2] = 64'h4142_0000_0000_0000; tbl_len[2] = 2;
        tbl_word[3] = 64'h4142_4300_0000_0000; tbl_len[3] = 3;
        tbl_word[4] = '1;                    tbl_len[4] = 8;
        load_table(DEF_MAX_KEYWORDS);
        send_len_key(4, 15, 8'hFF);
        write_count(5);

        send_match(8'h00);
        send_match(8'h41);
        send_match(8'h42);
        send_match(8'h43);
        send_match(8'h41);
        send_match(8'h42);
        send_match(8'h44);
        send_match(8'h41);
        send_cmd(rand_cmd(OP_RESTART));
        send_match(8'h00);
        repeat (DEF_MAX_KEYWORD_LEN) send_match(8'hFF);
        send_match(8'h7F);
        write_count(31);
        send_match(8'h41);
        write_count(5);
        send_match(8'h00);

        while (n_sent < TOTAL_ITEMS) run_phase();

        wait_idle();
        if (sb.expected_results.size() != 0)
            sb.note_error($sformatf("%0d expected results never arrived",
                                    sb.expected_results.size()));
        if (sb.errors == 0) begin
            $display("incremental_keyword_matcher_top verification clean");
        end else begin
            $display("incremental_keyword_matcher_top verification failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("incremental_keyword_matcher_top verification failed");
        $finish;
    end
endmodule
